FILE: hdl/transition_nearest_compound_search_defines.svh
// assertion macros shared by the checker
`ifndef TRANSITION_NEAREST_COMPOUND_SEARCH_DEFINES_SVH
`define TRANSITION_NEAREST_COMPOUND_SEARCH_DEFINES_SVH

// same-cycle implication, reset masks the check
`define TNCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define TNCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tncs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tncs_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_TOL_Q1      = 2'd0;
    localparam logic [1:0] REG_TOL_Q3      = 2'd1;
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;

    localparam int TOL_W   = 20;
    localparam int COUNT_W = 11;
    localparam int MZ_W    = 22;
    localparam int RT_W    = 16;
    localparam int IDX_W   = 10;
    localparam int SQ_W    = 2 * TOL_W;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 20'd512;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd0;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        entry_index;
        logic [MZ_W-1:0]         precursor_mz;
        logic [MZ_W-1:0]         product_mz;
        logic [RT_W-1:0]         retention_time;
        logic signed [3:0]       ion_charge;
    } t_query;

    typedef struct packed {
        logic                    found;
        logic [IDX_W-1:0]        best_index;
    } t_result;

    typedef struct packed {
        logic [MZ_W-1:0]         precursor_mz;
        logic [MZ_W-1:0]         product_mz;
        logic [RT_W-1:0]         retention_time;
        logic [3:0]              ion_charge;
    } t_entry;

    // token moving down the scan pipeline
    typedef struct packed {
        logic                    tok;
        logic                    ent;
        logic                    last;
        logic [IDX_W-1:0]        idx;
    } t_tag;

    typedef struct packed {
        t_tag                    tag;
        logic                    pass;
        logic [SQ_W-1:0]         sq_pre;
        logic [SQ_W-1:0]         sq_prod;
        logic [RT_W-1:0]         rt_gap;
    } t_cand;

endpackage

`default_nettype wire

FILE: hdl/transition_nearest_compound_search.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      payload
// item      in         start high, busy low           i_item (t_query)
// result    out        o_done strobe, one cycle       o_result (t_result)
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// a load writes an in-range entry and gives no result; busy stays low
// a query holds busy until all max(n, 1) reads have been evaluated, n the
// saturated entry count; o_done rises in the cycle busy falls
// the scan reads one entry a cycle through the single table read port
// reset clears control and config; table contents are undefined until loaded
// results cannot be held off; the next item may be taken while o_done is high

module transition_nearest_compound_search
    import tncs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  t_query             i_item,
    output logic               o_done,
    output t_result            o_result,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [1:0]          i_cfg_index,
    input  wire [TOL_W-1:0]    i_cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state              r_state;
    logic                r_busy;
    logic [CNT_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_n;
    t_query              r_query;
    t_tag                r_tag_rd;
    logic [TOL_W-1:0]    r_tol_q1;
    logic [TOL_W-1:0]    r_tol_q3;
    logic [COUNT_W-1:0]  r_entry_count;

    logic                n_accept;
    logic                n_we;
    logic [CNT_W-1:0]    n_count;
    t_tag                n_tag;
    t_entry              n_wdata;
    t_entry              n_rdata;
    t_cand               n_cand;

    always_comb begin
        n_accept = start && !r_busy;
        n_we     = n_accept && (i_item.cmd == CMD_LOAD)
                 && (32'(i_item.entry_index) < 32'(TABLE_DEPTH));
        n_count  = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                 : CNT_W'(r_entry_count);
        n_wdata.precursor_mz   = i_item.precursor_mz;
        n_wdata.product_mz     = i_item.product_mz;
        n_wdata.retention_time = i_item.retention_time;
        n_wdata.ion_charge     = i_item.ion_charge;
        n_tag.tok  = (r_state == S_SCAN);
        n_tag.ent  = (r_n != '0);
        n_tag.last = (r_n == '0) || ((r_addr + CNT_W'(1)) == r_n);
        n_tag.idx  = IDX_W'(r_addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_addr   <= '0;
            r_n      <= '0;
            r_tag_rd <= '0;
        end else begin
            r_tag_rd <= n_tag;
            case (r_state)
                S_IDLE: begin
                    if (n_accept && (i_item.cmd == CMD_QUERY)) begin
                        r_query <= i_item;
                        r_n     <= n_count;
                        r_addr  <= '0;
                        r_busy  <= 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (n_tag.last) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_addr <= r_addr + CNT_W'(1);
                    end
                end
                S_WAIT: begin
                    if (n_cand.tag.tok && n_cand.tag.last) begin
                        r_busy  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_q1      <= TOL_RESET;
            r_tol_q3      <= TOL_RESET;
            r_entry_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TOL_Q1:      r_tol_q1      <= i_cfg_data;
                REG_TOL_Q3:      r_tol_q3      <= i_cfg_data;
                REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tncs_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (ADDR_W'(i_item.entry_index)),
        .i_wdata (n_wdata),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (n_rdata)
    );

    tncs_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_tag_rd),
        .i_entry  (n_rdata),
        .i_query  (r_query),
        .i_tol_q1 (r_tol_q1),
        .i_tol_q3 (r_tol_q3),
        .o_cand   (n_cand)
    );

    tncs_best u_best (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cand   (n_cand),
        .o_done   (o_done),
        .o_result (o_result)
    );

    assign busy        = r_busy;
    // an item offered in the same cycle takes precedence over a register write
    assign o_cfg_ready = !r_busy && !start;

endmodule

`default_nettype wire

FILE: hdl/tncs_table.sv
`timescale 1ns / 1ps
`default_nettype none

module tncs_table
    import tncs_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire                i_clk,
    input  wire                i_we,
    input  wire [ADDR_W-1:0]   i_waddr,
    input  t_entry             i_wdata,
    input  wire [ADDR_W-1:0]   i_raddr,
    output t_entry             o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/tncs_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module tncs_eval
    import tncs_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_tag               i_tag,
    input  t_entry             i_entry,
    input  t_query             i_query,
    input  wire [TOL_W-1:0]    i_tol_q1,
    input  wire [TOL_W-1:0]    i_tol_q3,
    output t_cand              o_cand
);

    t_tag              r_tag_a;
    logic              r_pass_a;
    logic [TOL_W-1:0]  r_off_pre;
    logic [TOL_W-1:0]  r_off_prod;
    logic [RT_W-1:0]   r_gap_a;
    t_cand             r_cand;

    logic [MZ_W-1:0]   n_off_pre;
    logic [MZ_W-1:0]   n_off_prod;
    logic [RT_W-1:0]   n_gap;
    logic              n_pass;

    always_comb begin
        n_off_pre  = (i_entry.precursor_mz > i_query.precursor_mz)
                   ? i_entry.precursor_mz - i_query.precursor_mz
                   : i_query.precursor_mz - i_entry.precursor_mz;
        n_off_prod = (i_entry.product_mz > i_query.product_mz)
                   ? i_entry.product_mz - i_query.product_mz
                   : i_query.product_mz - i_entry.product_mz;
        n_gap      = (i_entry.retention_time > i_query.retention_time)
                   ? i_entry.retention_time - i_query.retention_time
                   : i_query.retention_time - i_entry.retention_time;
        n_pass     = (i_entry.precursor_mz != '0)
                   && ((i_entry.ion_charge == 4'd0)
                       || (i_entry.ion_charge == i_query.ion_charge))
                   && (n_off_pre <= {2'b00, i_tol_q1})
                   && (n_off_prod <= {2'b00, i_tol_q3});
    end

    // offset and filter stage, then squaring stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a      <= '0;
            r_cand.tag   <= '0;
        end else begin
            r_tag_a      <= i_tag;
            r_cand.tag   <= r_tag_a;
        end
        r_pass_a       <= n_pass;
        r_off_pre      <= n_off_pre[TOL_W-1:0];
        r_off_prod     <= n_off_prod[TOL_W-1:0];
        r_gap_a        <= n_gap;
        r_cand.pass    <= r_pass_a;
        r_cand.sq_pre  <= SQ_W'(r_off_pre) * SQ_W'(r_off_pre);
        r_cand.sq_prod <= SQ_W'(r_off_prod) * SQ_W'(r_off_prod);
        r_cand.rt_gap  <= r_gap_a;
    end

    assign o_cand = r_cand;

endmodule

`default_nettype wire

FILE: hdl/tncs_best.sv
`timescale 1ns / 1ps
`default_nettype none

module tncs_best
    import tncs_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cand              i_cand,
    output logic               o_done,
    output t_result            o_result
);

    logic               r_found;
    logic [SQ_W:0]      r_best_d;
    logic [RT_W-1:0]    r_best_gap;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_done;
    t_result            r_result;

    logic [SQ_W:0]      n_dist;
    logic               n_better;
    logic               n_final;

    always_comb begin
        n_dist   = {1'b0, i_cand.sq_pre} + {1'b0, i_cand.sq_prod};
        n_better = i_cand.tag.tok && i_cand.tag.ent && i_cand.pass
                 && (!r_found || (n_dist < r_best_d)
                     || ((n_dist == r_best_d) && (i_cand.rt_gap < r_best_gap)));
        n_final  = i_cand.tag.tok && i_cand.tag.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_final;
            if (n_final) begin
                r_found <= 1'b0;
            end else if (n_better) begin
                r_found <= 1'b1;
            end
        end
        if (n_better) begin
            r_best_d   <= n_dist;
            r_best_gap <= i_cand.rt_gap;
            r_best_idx <= i_cand.tag.idx;
        end
        if (n_final) begin
            r_result.found      <= n_better || r_found;
            r_result.best_index <= n_better ? i_cand.tag.idx
                                 : (r_found ? r_best_idx : '0);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hdl/tncs_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "transition_nearest_compound_search_defines.svh"

module tncs_check
    import tncs_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire                busy,
    input  t_query             i_item,
    input  wire                o_done,
    input  t_result            o_result,
    input  wire                i_cfg_valid,
    input  wire                o_cfg_ready,
    input  wire [1:0]          i_cfg_index,
    input  wire [TOL_W-1:0]    i_cfg_data
);

    `TNCS_ASSERT_NEXT(a_query_busy, start && !busy && (i_item.cmd == CMD_QUERY), busy, "query item did not raise busy")
    `TNCS_ASSERT_NEXT(a_load_quiet, start && !busy && (i_item.cmd == CMD_LOAD), !busy && !o_done, "load item raised busy or gave a result")
    `TNCS_ASSERT_NOW(a_done_on_fall, $fell(busy), o_done, "busy fell without a result")
    `TNCS_ASSERT_NOW(a_empty_index, o_done && !o_result.found, o_result.best_index == '0, "missing match with non-zero index")
    `TNCS_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")

endmodule

bind transition_nearest_compound_search tncs_check u_check (.*);

`default_nettype wire
